// ----- rtl/scm_pkg.sv -----
// shared types and constants of the stack calculator
package scm_pkg;

  localparam int VAL_W = 33;
  localparam int LIM_W = 31;
  localparam int MAG_W = 32;
  localparam logic [LIM_W-1:0] LIMIT_RESET = 31'd1000000000;

  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_EXEC   = 2'd1,
    KIND_FINISH = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    OP_NUM = 4'd0,
    OP_POP = 4'd1,
    OP_INV = 4'd2,
    OP_DUP = 4'd3,
    OP_SWP = 4'd4,
    OP_ADD = 4'd5,
    OP_SUB = 4'd6,
    OP_MUL = 4'd7,
    OP_DIV = 4'd8,
    OP_MOD = 4'd9
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_WAIT
  } state_t;

  // command to the shared multiply / divide unit
  typedef struct packed {
    logic start;
    logic is_div;
  } md_cmd_t;

endpackage

// ----- rtl/scm_muldiv.sv -----
// iterative unsigned 32x32 multiply and 32/32 divide on one shared add/subtract unit
module scm_muldiv (
  input  logic                    clk,
  input  logic                    rst,
  input  scm_pkg::md_cmd_t        cmd,
  input  logic [scm_pkg::MAG_W-1:0] a,
  input  logic [scm_pkg::MAG_W-1:0] b,
  output logic                    done,
  output logic [scm_pkg::MAG_W-1:0] hi,
  output logic [scm_pkg::MAG_W-1:0] lo
);
  import scm_pkg::*;

  logic [MAG_W-1:0] bq;
  logic [4:0]       cnt;
  logic             busy;
  logic             is_div;
  logic [MAG_W:0]   x;
  logic [MAG_W:0]   y;
  logic [MAG_W+1:0] r;

  // shared adder: add for multiply, subtract for divide
  always_comb begin
    if (is_div) begin
      x = {hi, lo[MAG_W-1]};
      y = {1'b0, bq};
      r = {1'b0, x} - {1'b0, y};
    end else begin
      x = {1'b0, hi};
      y = lo[0] ? {1'b0, bq} : '0;
      r = {1'b0, x} + {1'b0, y};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 5'd31) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      hi     <= '0;
      lo     <= a;
      bq     <= b;
      cnt    <= '0;
      is_div <= cmd.is_div;
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      if (is_div) begin
        hi <= r[MAG_W+1] ? x[MAG_W-1:0] : r[MAG_W-1:0];
        lo <= {lo[MAG_W-2:0], ~r[MAG_W+1]};
      end else begin
        hi <= r[MAG_W:1];
        lo <= {r[0], lo[MAG_W-1:1]};
      end
    end
  end

endmodule

// ----- rtl/stack_calculator_machine.sv -----
// stack machine calculator: top level with sequencer, stack memory and result register
// sequencing: start, finish, kind 3 and words after a latched error are taken in idle; other
// instructions pass accept, memory fetch and execute, and MUL and DIV / MOD with a
// nonzero divisor on two operands then wait for 32 steps of the shared add/subtract unit
// reset clears stack depth, error latch and output valid, and loads the limit with 1e9;
// the stack memory has no reset and no clearing pass; a waiting result word blocks the input
module stack_calculator_machine #(
  parameter int STACK_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // config write channel: magnitude_limit
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [30:0] cfg_data,
  // input words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // opcode[3:0], operand[35:4], zero fill
  input  logic [1:0]  s_tuser,   // kind[1:0]
  // result words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // top_value[32:0], zero fill
  output logic [0:0]  m_tuser    // error[0]
);
  import scm_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam logic [DW-1:0] DEPTH_MAX = DW'(STACK_DEPTH);

  state_t state, state_next;

  // machine state
  logic [DW-1:0]           depth;
  logic                    err;
  logic signed [VAL_W-1:0] top;      // top of stack lives here, memory holds the rest
  logic [LIM_W-1:0]        limit;

  // latched instruction
  op_t                     op;
  logic signed [31:0]      imm;

  // stack memory below the top
  logic [VAL_W-1:0]        mem [STACK_DEPTH];
  logic [VAL_W-1:0]        rd_data;
  logic [AW-1:0]           rd_addr;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;

  // result register
  logic                    out_valid;
  logic signed [VAL_W-1:0] out_value;
  logic                    out_err;

  logic                    accept;
  kind_t                   in_kind;
  logic signed [VAL_W-1:0] second;
  logic                    has_one, has_two, full;

  // add / sub path
  logic signed [VAL_W:0]   sum;
  logic [VAL_W:0]          sum_mag;
  logic                    sum_big;

  // multiply / divide path
  md_cmd_t                 md_cmd;
  logic                    md_done;
  logic [MAG_W-1:0]        md_hi, md_lo;
  logic [MAG_W-1:0]        mag_a, mag_b;
  logic [2*MAG_W-1:0]      md_mag;
  logic                    md_big, md_neg;
  logic signed [VAL_W-1:0] md_res;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE) && (!out_valid || m_tready);
  assign accept    = s_tvalid && s_tready;
  assign in_kind   = kind_t'(s_tuser);

  assign m_tvalid  = out_valid;
  assign m_tdata   = {7'b0, out_value};
  assign m_tuser   = out_err;

  assign second  = rd_data;
  assign has_one = depth != '0;
  assign has_two = depth > DW'(1);
  assign full    = depth == DEPTH_MAX;

  // entry just below the top, valid from the execute cycle on
  assign rd_addr = AW'(depth - DW'(2));

  // combinational add / sub with magnitude check
  always_comb begin
    if (op == OP_ADD) begin
      sum = {top[VAL_W-1], top} + {second[VAL_W-1], second};
    end else begin
      sum = {second[VAL_W-1], second} - {top[VAL_W-1], top};
    end
    sum_mag = sum[VAL_W] ? (VAL_W+1)'(-sum) : sum;
    sum_big = sum_mag > {3'b0, limit};
  end

  // operand magnitudes for the shared unit: a is the dividend / multiplier
  assign mag_a = second[VAL_W-1] ? MAG_W'(-second) : MAG_W'(second);
  assign mag_b = top[VAL_W-1] ? MAG_W'(-top) : MAG_W'(top);

  always_comb begin
    case (op)
      OP_MUL:  md_mag = {md_hi, md_lo};
      OP_DIV:  md_mag = {{MAG_W{1'b0}}, md_lo};
      default: md_mag = {{MAG_W{1'b0}}, md_hi};
    endcase
    md_big = md_mag > {{(2*MAG_W-LIM_W){1'b0}}, limit};
    md_neg = (op == OP_MOD) ? second[VAL_W-1] : (second[VAL_W-1] ^ top[VAL_W-1]);
    md_res = md_neg ? VAL_W'(-md_mag[VAL_W-1:0]) : VAL_W'(md_mag[VAL_W-1:0]);
  end

  // kick the shared unit for mul, and for div / mod with a nonzero divisor
  always_comb begin
    md_cmd.is_div = (op == OP_DIV) || (op == OP_MOD);
    md_cmd.start  = (state == ST_EXEC) && has_two &&
                    ((op == OP_MUL) || (md_cmd.is_div && top != '0));
  end

  scm_muldiv u_muldiv (
    .clk  (clk),
    .rst  (rst),
    .cmd  (md_cmd),
    .a    (mag_a),
    .b    (mag_b),
    .done (md_done),
    .hi   (md_hi),
    .lo   (md_lo)
  );

  // memory write: push spills the old top, swap stores the old top one down
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = AW'(depth - DW'(1));
    if (state == ST_EXEC) begin
      case (op)
        OP_NUM:  wr_en = has_one && !full;
        OP_DUP:  wr_en = has_one && !full;
        OP_SWP: begin
          wr_en   = has_two;
          wr_addr = rd_addr;
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= top;
    end
    rd_data <= mem[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept && in_kind == KIND_EXEC && !err) state_next = ST_FETCH;
      ST_FETCH: state_next = ST_EXEC;
      ST_EXEC:  state_next = md_cmd.start ? ST_WAIT : ST_IDLE;
      ST_WAIT:  if (md_done) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit <= cfg_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && in_kind == KIND_FINISH) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_kind == KIND_FINISH) begin
      out_err   <= err || depth != DW'(1);
      out_value <= (err || depth != DW'(1)) ? '0 : top;
    end
  end

  // latched instruction
  always_ff @(posedge clk) begin
    if (accept) begin
      op  <= op_t'(s_tdata[3:0]);
      imm <= s_tdata[35:4];
    end
  end

  // stack control and top of stack
  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
      err   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && in_kind == KIND_START) begin
            depth <= DW'(1);
            err   <= 1'b0;
            top   <= VAL_W'(signed'(s_tdata[35:4]));
          end
        end
        ST_EXEC: begin
          case (op)
            OP_NUM: begin
              if (full) begin
                err <= 1'b1;
              end else begin
                depth <= depth + DW'(1);
                top   <= VAL_W'(imm);
              end
            end
            OP_POP, OP_INV, OP_DUP, OP_SWP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
              if (!has_one) begin
                err <= 1'b1;
              end else if (op == OP_POP) begin
                depth <= depth - DW'(1);
                top   <= second;
              end else if (op == OP_INV) begin
                top <= -top;
              end else if (op == OP_DUP) begin
                if (full) err <= 1'b1;
                else depth <= depth + DW'(1);
              end else if (!has_two) begin
                err <= 1'b1;
              end else if (op == OP_SWP) begin
                top <= second;
              end else if (op == OP_ADD || op == OP_SUB) begin
                if (sum_big) begin
                  err <= 1'b1;
                end else begin
                  depth <= depth - DW'(1);
                  top   <= VAL_W'(sum);
                end
              end else if (op != OP_MUL && top == '0) begin
                // zero divisor
                err <= 1'b1;
              end
            end
            default: ;
          endcase
        end
        ST_WAIT: begin
          if (md_done) begin
            if (md_big) begin
              err <= 1'b1;
            end else begin
              depth <= depth - DW'(1);
              top   <= md_res;
            end
          end
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DEPTH_MAX) else $error("stack depth beyond capacity");

  a_err_value_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == '0)) else $error("error word carries a value");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    md_done |-> (state == ST_WAIT)) else $error("unit finished outside wait");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && in_kind == KIND_START) |=> (depth == DW'(1) && !err))
    else $error("start did not reset the stack");
`endif

endmodule

// ----- verif/tb_stack_calculator_machine.sv -----
// testbench for the stack calculator: directed cases and random programs checked against a built-in predictor
`timescale 1ns / 100ps

module tb_stack_calculator_machine;
  import scm_pkg::*;

  localparam int STACK_N = 1024;
  localparam logic [1:0] KIND_NONE = 2'd3;  // unused kind, must be ignored
  localparam int ITEM_GOAL = 1950;

  // expected finish report
  typedef struct {
    logic [VAL_W-1:0] top;
    logic             err;
  } report_t;

  // scoreboard: runs the stack program on accepted words, checks reports
  class calc_scoreboard;
    longint          stk[STACK_N];
    int unsigned     depth;
    bit              err_latch;
    longint          limit;
    report_t         reports[$];
    int              fails;

    function new();
      depth = 0;
      err_latch = 0;
      limit = LIMIT_RESET;
      fails = 0;
    endfunction

    function void push(longint v);
      if (depth >= STACK_N) begin
        err_latch = 1;
      end else begin
        stk[depth] = v;
        depth++;
      end
    endfunction

    function longint mag(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function void run_op(logic [3:0] opc, longint imm);
      longint first, second, res;
      res = 0;
      if (opc == OP_NUM) begin
        push(imm);
        return;
      end
      if (opc > OP_MOD) return;
      if (depth == 0) begin
        err_latch = 1;
        return;
      end
      first = stk[depth-1];
      case (opc)
        OP_POP: begin depth--; return; end
        OP_INV: begin stk[depth-1] = -first; return; end
        OP_DUP: begin push(first); return; end
        default: ;
      endcase
      if (depth < 2) begin
        err_latch = 1;
        return;
      end
      second = stk[depth-2];
      case (opc)
        OP_SWP: begin
          stk[depth-1] = second;
          stk[depth-2] = first;
          return;
        end
        OP_ADD: res = first + second;
        OP_SUB: res = second - first;
        OP_MUL: res = first * second;
        default: begin
          if (first == 0) begin
            err_latch = 1;
            return;
          end
          if (opc == OP_DIV) begin
            res = mag(second) / mag(first);
            if (((first < 0) != (second < 0)) && second != 0) res = -res;
          end else begin
            res = mag(second) % mag(first);
            if (second < 0) res = -res;
          end
        end
      endcase
      if (mag(res) > limit) begin
        err_latch = 1;
        return;
      end
      depth--;
      stk[depth-1] = res;
    endfunction

    // accepted input word
    function void note_word(logic [1:0] k, logic [3:0] opc, logic signed [31:0] imm);
      report_t r;
      case (k)
        KIND_START: begin
          depth = 0;
          err_latch = 0;
          push(longint'(imm));
        end
        KIND_EXEC: if (!err_latch) run_op(opc, longint'(imm));
        KIND_FINISH: begin
          if (err_latch || depth != 1) begin
            r.top = '0;
            r.err = 1'b1;
          end else begin
            r.top = stk[0][VAL_W-1:0];
            r.err = 1'b0;
          end
          reports = {reports, r};
        end
        default: ;
      endcase
    endfunction

    // accepted result word
    function void check_report(logic [VAL_W-1:0] top, logic err);
      report_t r;
      if (reports.size() == 0) begin
        $display("%0t: unexpected result top=%0d err=%0b", $time, $signed(top), err);
        fails++;
        return;
      end
      r = reports.pop_front();
      if (r.top !== top) begin
        $display("%0t: top_value expected %0d actual %0d", $time, $signed(r.top), $signed(top));
        fails++;
      end
      if (r.err !== err) begin
        $display("%0t: error expected %0b actual %0b", $time, r.err, err);
        fails++;
      end
    endfunction

    function int pending();
      return reports.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [30:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic [0:0]  m_tuser;

  calc_scoreboard sb;
  bit no_idle;           // both sides run without gaps
  int hold_req;          // long receiver hold-off requested by the stimulus
  int words_sent;

  stack_calculator_machine dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // watchdog, well above the slowest legal run
  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

  // result side: random stalls, plus the long hold-off when asked for
  initial begin
    int stall_left;
    bit taken;
    stall_left = 0;
    m_tready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      taken = m_tvalid && m_tready;
      if (taken) sb.check_report(m_tdata[VAL_W-1:0], m_tuser[0]);
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end else if (taken && !no_idle) begin
        stall_left = $urandom_range(0, 19);
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // one input word; valid stays up when the next word follows at once
  task automatic send_word(logic [1:0] k, logic [3:0] opc, logic [31:0] imm);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0 && s_tvalid) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end else if (gap > 0) begin
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, imm, opc};
    s_tuser  <= k;
    do @(posedge clk); while (!s_tready);
    sb.note_word(k, opc, imm);
    if (k != KIND_NONE) words_sent++;
  endtask

  // wait until every report is in and the block has gone quiet
  task automatic drain();
    if (s_tvalid) s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic write_limit(logic [30:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.limit = longint'(v);
    cfg_valid <= 1'b0;
  endtask

  // mostly small values so programs survive, some extremes and full-range noise
  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(0, 40) - 20;
      6: case ($urandom_range(0, 3))
           0: return 32'h8000_0000;
           1: return 32'h7fff_ffff;
           2: return 32'h0;
           default: return 32'hffff_ffff;
         endcase
      default: return $urandom;
    endcase
  endfunction

  // start, a run of instructions, finish; now and then broken or noisy
  task automatic rand_program();
    int n, r;
    if ($urandom_range(0, 29) != 0) send_word(KIND_START, OP_NUM, rand_val());
    n = $urandom_range(0, 12);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 30) send_word(KIND_EXEC, OP_NUM, rand_val());
      else if (r < 94) send_word(KIND_EXEC, 4'($urandom_range(OP_POP, OP_MOD)), $urandom);
      else if (r < 97) send_word(KIND_EXEC, 4'($urandom_range(OP_MOD + 1, 15)), $urandom);
      else send_word(KIND_NONE, 4'($urandom), $urandom);
    end
    send_word(KIND_FINISH, 4'($urandom), $urandom);
    if ($urandom_range(0, 9) == 0) send_word(KIND_FINISH, OP_NUM, 32'h0);
  endtask

  initial begin
    logic [30:0] limits[7];
    int ph;
    sb = new();
    no_idle = 0;
    hold_req = 0;
    words_sent = 0;
    rst = 1;
    cfg_valid = 0;
    cfg_data = '0;
    s_tvalid = 0;
    s_tdata = '0;
    s_tuser = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: instructions before any start, under the reset limit
    send_word(KIND_EXEC, OP_ADD, 32'h0);        // empty stack
    send_word(KIND_FINISH, OP_NUM, 32'h0);
    // extremes, then a double finish
    send_word(KIND_START, OP_NUM, 32'h7fff_ffff);
    send_word(KIND_EXEC, OP_NUM, 32'h8000_0000);
    send_word(KIND_EXEC, OP_ADD, 32'h0);
    send_word(KIND_FINISH, OP_NUM, 32'h0);
    send_word(KIND_FINISH, OP_NUM, 32'h0);
    // every operation but add, plus an unknown opcode and an unknown kind
    send_word(KIND_START, OP_NUM, 32'd7);
    send_word(KIND_EXEC, OP_NUM, -32'sd2);
    send_word(KIND_EXEC, OP_DIV, 32'h0);
    send_word(KIND_EXEC, OP_NUM, 32'd2);
    send_word(KIND_EXEC, OP_MOD, 32'h0);
    send_word(KIND_EXEC, OP_INV, 32'h0);
    send_word(KIND_EXEC, OP_DUP, 32'h0);
    send_word(KIND_EXEC, OP_SWP, 32'h0);
    send_word(KIND_EXEC, OP_MUL, 32'h0);
    send_word(KIND_EXEC, OP_NUM, 32'd5);
    send_word(KIND_EXEC, OP_SUB, 32'h0);
    send_word(KIND_EXEC, 4'(OP_MOD + 3), 32'hffff_ffff);
    send_word(KIND_NONE, OP_POP, 32'h0);
    send_word(KIND_EXEC, OP_POP, 32'h0);
    send_word(KIND_FINISH, OP_NUM, 32'h0);
    // zero divisor, then latched error ignores the rest
    send_word(KIND_START, OP_NUM, 32'd1);
    send_word(KIND_EXEC, OP_NUM, 32'd0);
    send_word(KIND_EXEC, OP_DIV, 32'h0);
    send_word(KIND_EXEC, OP_POP, 32'h0);
    send_word(KIND_FINISH, OP_NUM, 32'h0);
    // missing second operand
    send_word(KIND_START, OP_NUM, 32'd3);
    send_word(KIND_EXEC, OP_SWP, 32'h0);
    send_word(KIND_FINISH, OP_NUM, 32'h0);
    // result too large
    send_word(KIND_START, OP_NUM, 32'h4000_0000);
    send_word(KIND_EXEC, OP_DUP, 32'h0);
    send_word(KIND_EXEC, OP_MUL, 32'h0);
    send_word(KIND_FINISH, OP_NUM, 32'h0);

    // stack overflow: fill all entries, one more push faults
    no_idle = 1;
    send_word(KIND_START, OP_NUM, 32'd1);
    repeat (STACK_N - 1) send_word(KIND_EXEC, OP_DUP, 32'h0);
    send_word(KIND_EXEC, OP_NUM, 32'd9);
    send_word(KIND_FINISH, OP_NUM, 32'h0);
    no_idle = 0;

    // back pressure: receiver holds off while programs keep coming
    drain();
    hold_req = 400;
    repeat (8) rand_program();
    drain();

    // random programs under a series of limits, extremes and zero included
    limits = '{31'd1, 31'h7fff_ffff, 31'd0, 31'd1000, LIMIT_RESET, 31'd50, 31'd1000000};
    ph = 0;
    while (words_sent < ITEM_GOAL) begin
      write_limit((ph % 8 == 7) ? 31'($urandom) : limits[ph % 8 == 7 ? 0 : ph % 7]);
      no_idle = ($urandom_range(0, 3) == 0);
      repeat (25) rand_program();
      ph++;
    end
    no_idle = 0;

    drain();
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
